// ----- sv/rrcqd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrcqd_pkg
// shared types and codes for the round robin client queue dispatcher
// ----------------------------------------------------------------------------
package rrcqd_pkg;

  localparam logic [2:0] CMD_CONNECT    = 3'd0;
  localparam logic [2:0] CMD_DISCONNECT = 3'd1;
  localparam logic [2:0] CMD_ENQUEUE    = 3'd2;
  localparam logic [2:0] CMD_DISPATCH   = 3'd3;
  localparam logic [2:0] CMD_CHECK      = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_REJECTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_REFUSED  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] conn_id;
    logic [31:0] conn_epoch;
    logic [63:0] request_payload;
    logic        port_accepts;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        offer_valid;
    logic [15:0] offer_client_id;
    logic [31:0] offer_epoch;
    logic [63:0] offer_payload;
    logic        is_current;
    logic [31:0] drop_total;
    logic [31:0] full_total;
    logic [31:0] submitted_total;
  } out_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEND
  } bk_state_t;

endpackage

// ----- sv/rrcqd_front.sv -----
// ----------------------------------------------------------------------------
// rrcqd_front
// two-entry command queue at the input, stalling the sender while full
// ----------------------------------------------------------------------------
module rrcqd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rrcqd_pkg::in_item_t  in_data,
  output logic                 q_valid,
  input  logic                 q_pop,
  output rrcqd_pkg::in_item_t  q_data
);

  rrcqd_pkg::in_item_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ----- sv/rrcqd_back.sv -----
// ----------------------------------------------------------------------------
// rrcqd_back
// slot table, request store and command execution
// ----------------------------------------------------------------------------
module rrcqd_back #(
  parameter int CLIENT_SLOTS = 8,
  parameter int QUEUE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  rrcqd_pkg::in_item_t  q_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrcqd_pkg::out_item_t out_data
);

  localparam int SW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = SW + QW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(CLIENT_SLOTS - 1);
  localparam logic [QW-1:0] LAST_POS  = QW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);

  logic [CLIENT_SLOTS-1:0] used_r;
  logic [15:0]             client_r [CLIENT_SLOTS];
  logic [31:0]             epoch_r  [CLIENT_SLOTS];
  logic [QW-1:0]           head_r   [CLIENT_SLOTS];
  logic [CW-1:0]           count_r  [CLIENT_SLOTS];
  logic [PAYLOAD_BITS-1:0] store    [1 << AW];
  logic [PAYLOAD_BITS-1:0] rd_r;
  logic [SW-1:0]           next_r;
  logic [31:0]             drop_r, full_r, sub_r;

  rrcqd_pkg::bk_state_t state_r, state_nxt;
  rrcqd_pkg::out_item_t res_r, res_nxt;
  rrcqd_pkg::in_item_t  cmd;

  // match, free-slot and pending-slot search
  logic          hit, free_found, pend_found;
  logic [SW-1:0] hit_idx, free_idx, pend_idx, idx;
  logic          ep_ok;
  logic [SW-1:0] ord;

  always_comb begin
    hit = 1'b0; hit_idx = '0; free_found = 1'b0; free_idx = '0;
    pend_found = 1'b0; pend_idx = '0; ord = '0;
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && client_r[i] == cmd.conn_id) begin
        hit = 1'b1; hit_idx = SW'(i);
      end
      if (!used_r[i]) begin
        free_found = 1'b1; free_idx = SW'(i);
      end
    end
    // round robin: first pending at or after next_r, else first overall
    for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
      if (used_r[i] && count_r[i] != '0) begin
        if (SW'(i) >= next_r || !pend_found || ord < next_r) begin
          if (!(SW'(i) < next_r && pend_found && ord >= next_r)) begin
            pend_found = 1'b1; pend_idx = SW'(i); ord = SW'(i);
          end
        end
      end
    end
  end

  assign cmd   = q_data;
  assign ep_ok = hit && (epoch_r[hit_idx] == cmd.conn_epoch);
  assign idx   = (cmd.command == rrcqd_pkg::CMD_DISPATCH) ? pend_idx : hit_idx;

  logic [QW-1:0] tail;
  logic [QW:0]   tsum;
  assign tsum = {1'b0, head_r[idx]} + (QW+1)'(count_r[idx]);
  assign tail = (tsum > (QW+1)'(LAST_POS)) ? QW'(tsum - (QW+1)'(QUEUE_DEPTH)) : QW'(tsum);

  // result of the command at the head of the queue
  always_comb begin
    res_nxt = '0;
    res_nxt.status = rrcqd_pkg::ST_REJECTED;
    unique case (cmd.command)
      rrcqd_pkg::CMD_CONNECT: begin
        if (cmd.conn_epoch != '0 && !hit && free_found) res_nxt.status = rrcqd_pkg::ST_OK;
      end
      rrcqd_pkg::CMD_DISCONNECT: begin
        if (ep_ok) res_nxt.status = rrcqd_pkg::ST_OK;
      end
      rrcqd_pkg::CMD_ENQUEUE: begin
        if (ep_ok) begin
          res_nxt.status = (count_r[idx] >= DEPTH_C) ? rrcqd_pkg::ST_FULL : rrcqd_pkg::ST_OK;
        end
      end
      rrcqd_pkg::CMD_DISPATCH: begin
        res_nxt.status = rrcqd_pkg::ST_EMPTY;
        if (pend_found) begin
          res_nxt.offer_valid     = 1'b1;
          res_nxt.offer_client_id = client_r[idx];
          res_nxt.offer_epoch     = epoch_r[idx];
          res_nxt.status = cmd.port_accepts ? rrcqd_pkg::ST_OK : rrcqd_pkg::ST_REFUSED;
        end
      end
      rrcqd_pkg::CMD_CHECK: begin
        res_nxt.is_current = ep_ok;
        res_nxt.status     = rrcqd_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrcqd_pkg::BK_IDLE: if (q_valid) state_nxt = rrcqd_pkg::BK_READ;
      rrcqd_pkg::BK_READ: state_nxt = rrcqd_pkg::BK_SEND;
      rrcqd_pkg::BK_SEND: if (!out_stall) state_nxt = rrcqd_pkg::BK_IDLE;
      default:            state_nxt = rrcqd_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      rrcqd_pkg::BK_SEND: begin
        out_valid = 1'b1;
        q_pop     = !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == rrcqd_pkg::BK_IDLE && q_valid) begin
      rd_r  <= store[{idx, head_r[idx]}];
      res_r <= res_nxt;
      if (cmd.command == rrcqd_pkg::CMD_ENQUEUE && ep_ok && count_r[idx] < DEPTH_C) begin
        store[{idx, tail}] <= cmd.request_payload[PAYLOAD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrcqd_pkg::BK_IDLE;
      used_r  <= '0;
      next_r  <= '0;
      drop_r  <= '0;
      full_r  <= '0;
      sub_r   <= '0;
      for (int i = 0; i < CLIENT_SLOTS; i++) begin
        client_r[i] <= '0; epoch_r[i] <= '0; head_r[i] <= '0; count_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == rrcqd_pkg::BK_IDLE && q_valid) begin
        unique case (cmd.command)
          rrcqd_pkg::CMD_CONNECT: begin
            if (cmd.conn_epoch != '0 && !hit && free_found) begin
              used_r[free_idx]   <= 1'b1;
              client_r[free_idx] <= cmd.conn_id;
              epoch_r[free_idx]  <= cmd.conn_epoch;
              head_r[free_idx]   <= '0;
              count_r[free_idx]  <= '0;
            end
          end
          rrcqd_pkg::CMD_DISCONNECT: begin
            if (ep_ok) begin
              drop_r <= drop_r + 32'(count_r[idx]);
              used_r[idx] <= 1'b0; client_r[idx] <= '0; epoch_r[idx] <= '0;
              head_r[idx] <= '0; count_r[idx] <= '0;
            end
          end
          rrcqd_pkg::CMD_ENQUEUE: begin
            if (ep_ok) begin
              if (count_r[idx] >= DEPTH_C) begin
                full_r <= full_r + 32'd1;
              end else begin
                count_r[idx] <= count_r[idx] + CW'(1);
              end
            end
          end
          rrcqd_pkg::CMD_DISPATCH: begin
            if (pend_found) begin
              next_r <= (idx == LAST_SLOT) ? '0 : idx + SW'(1);
              if (cmd.port_accepts) begin
                head_r[idx]  <= (head_r[idx] == LAST_POS) ? '0 : head_r[idx] + QW'(1);
                count_r[idx] <= count_r[idx] - CW'(1);
                sub_r <= sub_r + 32'd1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_data = res_r;
    out_data.offer_payload   = res_r.offer_valid ? 64'(rd_r) : '0;
    out_data.drop_total      = drop_r;
    out_data.full_total      = full_r;
    out_data.submitted_total = sub_r;
  end

endmodule

// ----- sv/round_robin_client_queue_dispatcher.sv -----
// ----------------------------------------------------------------------------
// round_robin_client_queue_dispatcher
// client slot table with per-client request rings, dispatched round robin
// ----------------------------------------------------------------------------
// path: command queue register, then BK_IDLE (table update and registered
// store read), BK_READ and BK_SEND, which holds the result until it is taken
// flow: the back end takes a new command only after the last result is taken
// reset: synchronous, active low; slot table and counters clear at once,
// request store holds no reset
module round_robin_client_queue_dispatcher #(
  parameter int CLIENT_SLOTS = 8,
  parameter int QUEUE_DEPTH  = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rrcqd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rrcqd_pkg::out_item_t out_data
);

  // command queue between front and back
  logic                q_valid, q_pop;
  rrcqd_pkg::in_item_t q_data;

  rrcqd_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .q_valid, .q_pop, .q_data
  );

  // back end executes one command per transaction
  rrcqd_back #(
    .CLIENT_SLOTS(CLIENT_SLOTS), .QUEUE_DEPTH(QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ----- tb/tb_round_robin_client_queue_dispatcher.sv -----
// ----------------------------------------------------------------------------
// tb_round_robin_client_queue_dispatcher
// self-checking bench: directed table, then random client sessions, checked
// against a behavioural slot table with round robin dispatch
// ----------------------------------------------------------------------------
module tb_round_robin_client_queue_dispatcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;
  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  rrcqd_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  rrcqd_pkg::out_item_t out_data;

  round_robin_client_queue_dispatcher uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // shadow of the slot table
  logic        sh_used  [SLOTS];
  logic [15:0] sh_client[SLOTS];
  logic [31:0] sh_epoch [SLOTS];
  logic [2:0]  sh_head  [SLOTS];
  logic [3:0]  sh_count [SLOTS];
  logic [63:0] sh_ring  [SLOTS*DEPTH];
  logic [2:0]  sh_next;
  logic [31:0] sh_drops, sh_fulls, sh_submits;

  rrcqd_pkg::out_item_t pending_results[$];
  int          mismatches;
  int          cycles;
  logic        drain_hold;   // receiver's long hold-off request
  logic        stim_done;

  // client pool used by random sessions, small so ids collide often
  logic [15:0] pool_id[12];
  logic [31:0] pool_epoch[12];

  function automatic int slot_of(logic [15:0] id);
    for (int i = 0; i < SLOTS; i++)
      if (sh_used[i] && sh_client[i] == id) return i;
    return -1;
  endfunction

  // advance the shadow by one transaction and return the result it should give
  function automatic rrcqd_pkg::out_item_t dispatcher_step(rrcqd_pkg::in_item_t t);
    rrcqd_pkg::out_item_t r;
    int s;
    int idx;
    logic [2:0] tail;
    r = '0;
    r.status = rrcqd_pkg::ST_REJECTED;
    case (t.command)
      rrcqd_pkg::CMD_CONNECT: begin
        if (t.conn_epoch != 0 && slot_of(t.conn_id) < 0) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!sh_used[i]) begin
              sh_used[i] = 1'b1; sh_client[i] = t.conn_id;
              sh_epoch[i] = t.conn_epoch; sh_head[i] = '0; sh_count[i] = '0;
              r.status = rrcqd_pkg::ST_OK;
              break;
            end
          end
        end
      end
      rrcqd_pkg::CMD_DISCONNECT: begin
        s = slot_of(t.conn_id);
        if (s >= 0 && sh_epoch[s] == t.conn_epoch) begin
          sh_drops += 32'(sh_count[s]);
          sh_used[s] = 1'b0; sh_client[s] = '0; sh_epoch[s] = '0;
          sh_head[s] = '0; sh_count[s] = '0;
          r.status = rrcqd_pkg::ST_OK;
        end
      end
      rrcqd_pkg::CMD_ENQUEUE: begin
        s = slot_of(t.conn_id);
        if (s >= 0 && sh_epoch[s] == t.conn_epoch) begin
          if (sh_count[s] >= DEPTH) begin
            sh_fulls += 32'd1;
            r.status = rrcqd_pkg::ST_FULL;
          end else begin
            tail = sh_head[s] + sh_count[s][2:0];
            sh_ring[s*DEPTH + tail] = t.request_payload;
            sh_count[s] += 4'd1;
            r.status = rrcqd_pkg::ST_OK;
          end
        end
      end
      rrcqd_pkg::CMD_DISPATCH: begin
        r.status = rrcqd_pkg::ST_EMPTY;
        for (int n = 0; n < SLOTS; n++) begin
          idx = (sh_next + n) % SLOTS;
          if (!sh_used[idx] || sh_count[idx] == 0) continue;
          r.offer_valid = 1'b1;
          r.offer_client_id = sh_client[idx];
          r.offer_epoch = sh_epoch[idx];
          r.offer_payload = sh_ring[idx*DEPTH + sh_head[idx]];
          sh_next = 3'((idx + 1) % SLOTS);
          if (t.port_accepts) begin
            sh_head[idx] += 3'd1; sh_count[idx] -= 4'd1; sh_submits += 32'd1;
            r.status = rrcqd_pkg::ST_OK;
          end else begin
            r.status = rrcqd_pkg::ST_REFUSED;
          end
          break;
        end
      end
      rrcqd_pkg::CMD_CHECK: begin
        s = slot_of(t.conn_id);
        r.is_current = (s >= 0 && sh_epoch[s] == t.conn_epoch);
        r.status = rrcqd_pkg::ST_OK;
      end
      default: ;
    endcase
    r.drop_total = sh_drops;
    r.full_total = sh_fulls;
    r.submitted_total = sh_submits;
    return r;
  endfunction

  // ---------------- directed table ----------------
  typedef struct {
    rrcqd_pkg::in_item_t  item;
    logic                 typed;     // expected result typed in below
    rrcqd_pkg::out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic rrcqd_pkg::in_item_t mk(logic [2:0] c, logic [15:0] id,
                                             logic [31:0] ep, logic [63:0] pl,
                                             logic acc);
    rrcqd_pkg::in_item_t t;
    t.command = c; t.conn_id = id; t.conn_epoch = ep;
    t.request_payload = pl; t.port_accepts = acc;
    return t;
  endfunction

  function automatic rrcqd_pkg::out_item_t st_only(logic [2:0] st);
    rrcqd_pkg::out_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  task automatic add_row(rrcqd_pkg::in_item_t t, logic typed, rrcqd_pkg::out_item_t w);
    dir_row_t d;
    d.item = t; d.typed = typed; d.want = w;
    dir_rows.push_back(d);
  endtask

  initial begin
    // after reset: nothing queued, unknown client, bad epoch, unused codes
    add_row(mk(rrcqd_pkg::CMD_DISPATCH, 16'h0, 32'h0, 64'h0, 1'b1), 1'b1,
            st_only(rrcqd_pkg::ST_EMPTY));
    add_row(mk(rrcqd_pkg::CMD_CHECK, 16'hFFFF, 32'hFFFF_FFFF, 64'h0, 1'b0), 1'b1,
            st_only(rrcqd_pkg::ST_OK));
    add_row(mk(rrcqd_pkg::CMD_CONNECT, 16'h1, 32'h0, 64'h0, 1'b0), 1'b1,
            st_only(rrcqd_pkg::ST_REJECTED));
    add_row(mk(rrcqd_pkg::CMD_DISCONNECT, 16'h1, 32'h1, 64'h0, 1'b0), 1'b1,
            st_only(rrcqd_pkg::ST_REJECTED));
    add_row(mk(rrcqd_pkg::CMD_ENQUEUE, 16'h1, 32'h1, 64'h5, 1'b0), 1'b1,
            st_only(rrcqd_pkg::ST_REJECTED));
    add_row(mk(3'd5, 16'hFFFF, 32'hFFFF_FFFF, '1, 1'b1), 1'b1,
            st_only(rrcqd_pkg::ST_REJECTED));
    add_row(mk(3'd6, 16'h0, 32'h1, 64'h0, 1'b0), 1'b1, st_only(rrcqd_pkg::ST_REJECTED));
    add_row(mk(3'd7, 16'h0, 32'h1, 64'h0, 1'b1), 1'b1, st_only(rrcqd_pkg::ST_REJECTED));
    // extremes: id 0 and all-ones, epoch all-ones, payload extremes
    add_row(mk(rrcqd_pkg::CMD_CONNECT, 16'h0, 32'hFFFF_FFFF, 64'h0, 1'b0), 1'b0, '0);
    add_row(mk(rrcqd_pkg::CMD_CONNECT, 16'hFFFF, 32'h1, 64'h0, 1'b0), 1'b0, '0);
    add_row(mk(rrcqd_pkg::CMD_CONNECT, 16'h0, 32'h7, 64'h0, 1'b0), 1'b0, '0); // duplicate id
    add_row(mk(rrcqd_pkg::CMD_CHECK, 16'h0, 32'hFFFF_FFFE, 64'h0, 1'b0), 1'b0, '0); // stale
    add_row(mk(rrcqd_pkg::CMD_ENQUEUE, 16'h0, 32'hFFFF_FFFF, '1, 1'b0), 1'b0, '0);
    add_row(mk(rrcqd_pkg::CMD_ENQUEUE, 16'hFFFF, 32'h1, 64'h0, 1'b0), 1'b0, '0);
    add_row(mk(rrcqd_pkg::CMD_ENQUEUE, 16'hFFFF, 32'h1, 64'h8000_0000_0000_0001, 1'b1),
            1'b0, '0);
    add_row(mk(rrcqd_pkg::CMD_DISPATCH, 16'h0, 32'h0, 64'h0, 1'b0), 1'b0, '0); // refused
    add_row(mk(rrcqd_pkg::CMD_DISPATCH, 16'h0, 32'h0, 64'h0, 1'b1), 1'b0, '0);
    add_row(mk(rrcqd_pkg::CMD_DISPATCH, 16'h0, 32'h0, 64'h0, 1'b1), 1'b0, '0);
    add_row(mk(rrcqd_pkg::CMD_DISCONNECT, 16'hFFFF, 32'h2, 64'h0, 1'b0), 1'b0, '0); // wrong ep
    add_row(mk(rrcqd_pkg::CMD_DISCONNECT, 16'hFFFF, 32'h1, 64'h0, 1'b0), 1'b0, '0); // drops
    add_row(mk(rrcqd_pkg::CMD_CHECK, 16'h0, 32'hFFFF_FFFF, 64'h0, 1'b0), 1'b0, '0);
  end

  // ---------------- stimulus ----------------
  rrcqd_pkg::in_item_t sent_items[$];   // queue of input items, never filled; the predictor takes in_data directly

  // valid drops only when an idle gap follows
  task automatic send_one(rrcqd_pkg::in_item_t t);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // burst variant: back to back, no gaps, to fill the block during a hold-off
  task automatic send_burst(rrcqd_pkg::in_item_t t);
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic rrcqd_pkg::in_item_t rand_item();
    rrcqd_pkg::in_item_t t;
    int k;
    int pick;
    k = $urandom_range(0, 11);
    t.conn_id = pool_id[k];
    t.conn_epoch = pool_epoch[k];
    t.request_payload = {$urandom, $urandom};
    t.port_accepts = $urandom_range(0, 3) != 0;
    pick = $urandom_range(0, 99);
    if (pick < 12)      t.command = rrcqd_pkg::CMD_CONNECT;
    else if (pick < 20) t.command = rrcqd_pkg::CMD_DISCONNECT;
    else if (pick < 55) t.command = rrcqd_pkg::CMD_ENQUEUE;
    else if (pick < 85) t.command = rrcqd_pkg::CMD_DISPATCH;
    else if (pick < 95) t.command = rrcqd_pkg::CMD_CHECK;
    else                t.command = 3'($urandom_range(5, 7));
    // noise: random id or epoch, sometimes an epoch of zero
    if ($urandom_range(0, 9) == 0) t.conn_id = 16'($urandom);
    if ($urandom_range(0, 9) == 0) t.conn_epoch = $urandom_range(0, 1) ? $urandom : 32'h0;
    return t;
  endfunction

  // predictor runs on accepted input transactions, in order
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      pending_results.push_back(dispatcher_step(in_data));
  end

  // directed rows with a typed result are also checked against the predictor
  // as they arrive; check the typed fields once here against the block output
  task automatic check_typed(rrcqd_pkg::out_item_t got, rrcqd_pkg::out_item_t want);
    if (got.status !== want.status || got.offer_valid !== want.offer_valid ||
        got.is_current !== want.is_current) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row: expected status %0d offer %0b current %0b, got %0d %0b %0b",
                 want.status, want.offer_valid, want.is_current,
                 got.status, got.offer_valid, got.is_current);
    end
  endtask

  initial begin
    rrcqd_pkg::in_item_t t;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; stim_done = 1'b0; drain_hold = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_used[i] = 1'b0; sh_client[i] = '0; sh_epoch[i] = '0; sh_head[i] = '0;
      sh_count[i] = '0;
    end
    for (int i = 0; i < SLOTS*DEPTH; i++) sh_ring[i] = '0;
    sh_next = '0; sh_drops = '0; sh_fulls = '0; sh_submits = '0;
    for (int i = 0; i < 12; i++) begin
      pool_id[i] = (i == 0) ? 16'h0 : (i == 1) ? 16'hFFFF : 16'($urandom);
      pool_epoch[i] = (i == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 32'h7FFF_FFFF));
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part; typed rows compare against the predictor output too
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        rrcqd_pkg::out_item_t w;
        w = dir_rows[i].want;
        // typed results fix only status, offer and current; counters are zero here
        if (w.status !== rrcqd_pkg::ST_OK && w.status !== rrcqd_pkg::ST_REJECTED &&
            w.status !== rrcqd_pkg::ST_EMPTY)
          mismatches++;
      end
      send_one(dir_rows[i].item);
    end

    // connect the whole pool so sessions have a table to work on
    for (int i = 0; i < 12; i++)
      send_one(mk(rrcqd_pkg::CMD_CONNECT, pool_id[i], pool_epoch[i], 64'h0, 1'b0));

    // random sessions
    for (int n = 0; n < 200; n++) send_one(rand_item());

    // long receiver hold-off while the sender keeps offering
    drain_hold <= 1'b1;
    for (int n = 0; n < 20; n++) begin
      t = rand_item();
      if (t.command > rrcqd_pkg::CMD_CHECK) t.command = rrcqd_pkg::CMD_ENQUEUE;
      send_burst(t);
    end
    in_valid <= 1'b0;

    // sender pauses until every expected result has arrived
    while (pending_results.size() != 0) @(posedge clk);

    for (int n = 0; n < 220; n++) send_one(rand_item());
    in_valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // typed rows: the first eight directed rows run from reset, so their status,
  // offer and current fields are checked against typed values as they arrive
  int typed_seen;

  // ---------------- receiver ----------------
  int hold_count;
  initial begin
    int wait_cycles;
    out_stall = 1'b1;
    hold_count = 0;
    @(posedge rst_n);
    forever begin
      if (drain_hold) begin
        out_stall <= 1'b1;
        hold_count++;
        if (hold_count >= 200) begin
          drain_hold <= 1'b0;   // stays low from here on
          hold_count = -1000000;
        end
        @(posedge clk);
      end else begin
        wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 19);
        if (wait_cycles > 0) begin
          out_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // ---------------- checker ----------------
  initial typed_seen = 0;
  initial mismatches = 0;

  always @(posedge clk) begin
    rrcqd_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", out_data);
      end else begin
        want = pending_results.pop_front();
        if (typed_seen < dir_rows.size() && dir_rows[typed_seen].typed)
          check_typed(out_data, dir_rows[typed_seen].want);
        typed_seen++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected st=%0d ov=%0b id=%h ep=%h pl=%h cur=%0b %h/%h/%h",
                     want.status, want.offer_valid, want.offer_client_id, want.offer_epoch,
                     want.offer_payload, want.is_current, want.drop_total,
                     want.full_total, want.submitted_total);
          if (mismatches <= 10)
            $display("                 got      st=%0d ov=%0b id=%h ep=%h pl=%h cur=%0b %h/%h/%h",
                     out_data.status, out_data.offer_valid, out_data.offer_client_id,
                     out_data.offer_epoch, out_data.offer_payload, out_data.is_current,
                     out_data.drop_total, out_data.full_total, out_data.submitted_total);
        end
      end
    end
  end

  // ---------------- end of run ----------------
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (stim_done && in_valid == 1'b0 && pending_results.size() == 0) begin
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
          $display("SCOREBOARD CLEAN");
        end else begin
          $display("SCOREBOARD MISMATCH");
        end
        $finish;
      end
    end
  end

endmodule
